>>> rtl/core/sgfp_pkg.sv
// ============================================================================
// sgfp_pkg - shared definitions for the softened gravity force block
// Widths, register indexes and the square-root stage record and step.
// ============================================================================
package sgfp_pkg;

    localparam int DATA_W    = 32;
    localparam int CFG_W     = 31;
    localparam int ADDR_W    = 3;
    localparam int SQRT_STEPS = 32;
    localparam int QUO_W     = 32;

    // Register index, taken from paddr[2].
    localparam logic REG_TOTAL_MASS = 1'b0;
    localparam logic REG_SOFTENING  = 1'b1;

    // One record of the square-root pipeline.
    typedef struct packed {
        logic                   valid;
        logic                   zero;
        logic [63:0]            rem;
        logic [63:0]            root;
        logic [63:0]            s;
        logic [2:0][31:0]       mag;
        logic [2:0]             neg;
    } sqrt_stage_t;

    // One digit of the bit-by-bit integer square root.
    function automatic sqrt_stage_t sqrt_step(input sqrt_stage_t st, input int step);
        sqrt_stage_t res;
        logic [63:0] bit_val;
        logic [63:0] trial;
        res     = st;
        bit_val = 64'd1 << (62 - 2 * step);
        trial   = st.root + bit_val;
        if (st.rem >= trial)
        begin
            res.rem  = st.rem - trial;
            res.root = (st.root >> 1) + bit_val;
        end
        else
        begin
            res.root = st.root >> 1;
        end
        return res;
    endfunction

endpackage

>>> rtl/core/sgfp_div.sv
// ============================================================================
// sgfp_div - pipelined restoring divider
// One quotient bit per stage, with an overflow flag for quotients that do
// not fit in QUO_W bits. A tag travels alongside the data.
// ============================================================================
module sgfp_div #(
    parameter int NUM_W = 95,
    parameter int DEN_W = 96,
    parameter int QUO_W = 32,
    parameter int TAG_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [TAG_W-1:0] tag_in,
    output logic [QUO_W-1:0] quo,
    output logic             ovf,
    output logic [TAG_W-1:0] tag_out
);

    localparam int REM_W = (NUM_W > DEN_W + QUO_W + 1) ? NUM_W : DEN_W + QUO_W + 1;

    logic [REM_W-1:0] rem_reg [0:QUO_W];
    logic [DEN_W-1:0] den_reg [0:QUO_W];
    logic [QUO_W-1:0] quo_reg [0:QUO_W];
    logic             ovf_reg [0:QUO_W];
    logic [TAG_W-1:0] tag_reg [0:QUO_W];

    // Entry stage: the quotient overflows when num >= den * 2^QUO_W.
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= REM_W'(num);
        den_reg[0] <= den;
        quo_reg[0] <= '0;
        ovf_reg[0] <= (REM_W'(num) >= (REM_W'(den) << QUO_W));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_reg[0] <= '0;
        else
            tag_reg[0] <= tag_in;
    end

    for (genvar j = 0; j < QUO_W; j++)
    begin : g_stage
        localparam int B = QUO_W - 1 - j;
        logic [REM_W-1:0] dsh;

        assign dsh = REM_W'(den_reg[j]) << B;

        always_ff @(posedge clk)
        begin
            den_reg[j+1] <= den_reg[j];
            ovf_reg[j+1] <= ovf_reg[j];
            if (rem_reg[j] >= dsh)
            begin
                rem_reg[j+1] <= rem_reg[j] - dsh;
                quo_reg[j+1] <= quo_reg[j] | (QUO_W'(1) << B);
            end
            else
            begin
                rem_reg[j+1] <= rem_reg[j];
                quo_reg[j+1] <= quo_reg[j];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                tag_reg[j+1] <= '0;
            else
                tag_reg[j+1] <= tag_reg[j];
        end
    end

    assign quo     = quo_reg[QUO_W];
    assign ovf     = ovf_reg[QUO_W];
    assign tag_out = tag_reg[QUO_W];

endmodule

>>> rtl/core/softened_gravity_force_potential.sv
// ============================================================================
// softened_gravity_force_potential - Plummer-softened gravity, streaming
// Computes per-axis force -M*pos/s^1.5 and potential -M/sqrt(s), with
// s = |pos|^2 + b^2, in saturated signed fixed point.
// ============================================================================
//
//  Channel   Handshake                    Payload
//  --------  ---------------------------  ------------------------------------
//  input     start (taken when !busy)     pos_x, pos_y, pos_z
//  result    done (one-cycle strobe)      force_x, force_y, force_z, potential
//  config    APB psel/penable/pwrite      total_mass (0x0), softening_length (0x4)
//
// A beat can be accepted on every clock cycle; busy is held low. Each beat
// passes through one input stage, the square and sum stages, thirty-two
// stages of the bit-serial square root, two stages that build numerator and
// denominator, thirty-three stages of the restoring dividers and one
// saturation stage. Reset clears only the valid bits, the divider tags and
// the two registers (both to 1.0). The receiver cannot stall the results, so
// the pipeline never holds. Registers are only to be written while idle.
//
module softened_gravity_force_potential
    import sgfp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // input beat
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] pos_x,
    input  logic signed [DATA_W-1:0] pos_y,
    input  logic signed [DATA_W-1:0] pos_z,
    // result beat
    output logic                     done,
    output logic signed [DATA_W-1:0] force_x,
    output logic signed [DATA_W-1:0] force_y,
    output logic signed [DATA_W-1:0] force_z,
    output logic signed [DATA_W-1:0] potential,
    // configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int FNUM_W = CFG_W + DATA_W + 2 * FRAC_BITS;
    localparam int FDEN_W = 96;
    localparam int PNUM_W = CFG_W + FRAC_BITS;
    localparam int PDEN_W = 32;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] mass_reg;
    logic [CFG_W-1:0] soft_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mass_reg <= CFG_W'(65536);
            soft_reg <= CFG_W'(65536);
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_TOTAL_MASS: mass_reg <= pwdata[CFG_W-1:0];
                REG_SOFTENING:  soft_reg <= pwdata[CFG_W-1:0];
                default:        mass_reg <= mass_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_TOTAL_MASS: prdata = {1'b0, mass_reg};
            REG_SOFTENING:  prdata = {1'b0, soft_reg};
            default:        prdata = '0;
        endcase
    end

    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: magnitudes and signs of the coordinates
    // ------------------------------------------------------------------
    logic             v1_reg;
    logic [2:0][31:0] mag1_reg;
    logic [2:0]       neg1_reg;
    logic [2:0][31:0] pos_in;

    assign pos_in = {pos_z, pos_y, pos_x};

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            neg1_reg[k] <= pos_in[k][31];
            mag1_reg[k] <= pos_in[k][31] ? (32'd0 - pos_in[k]) : pos_in[k];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squares
    // ------------------------------------------------------------------
    logic             v2_reg;
    logic [2:0][63:0] sq2_reg;
    logic [63:0]      sqb2_reg;
    logic [2:0][31:0] mag2_reg;
    logic [2:0]       neg2_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
            sq2_reg[k] <= mag1_reg[k] * mag1_reg[k];
        sqb2_reg <= 64'(soft_reg) * 64'(soft_reg);
        mag2_reg <= mag1_reg;
        neg2_reg <= neg1_reg;
    end

    // ------------------------------------------------------------------
    // Stage 3: sum of squares, kept modulo 2^64
    // ------------------------------------------------------------------
    sqrt_stage_t sqrt_reg [0:SQRT_STEPS];
    logic        v_sqrt_reg [0:SQRT_STEPS];
    sqrt_stage_t st3;
    logic [63:0] s3;

    always_comb
    begin
        s3        = sq2_reg[0] + sq2_reg[1] + sq2_reg[2] + sqb2_reg;
        st3.valid = v2_reg;
        st3.zero  = (s3 == 64'd0);
        st3.rem   = s3;
        st3.root  = '0;
        st3.s     = s3;
        st3.mag   = mag2_reg;
        st3.neg   = neg2_reg;
    end

    always_ff @(posedge clk)
    begin
        sqrt_reg[0] <= st3;
    end

    // Square root, one result bit per stage.
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        always_ff @(posedge clk)
        begin
            sqrt_reg[k+1] <= sqrt_step(sqrt_reg[k], k);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_sqrt_reg[k+1] <= 1'b0;
            else
                v_sqrt_reg[k+1] <= v_sqrt_reg[k];
        end
    end

    // ------------------------------------------------------------------
    // Multiply stage: partial products of s*r and M*|pos|
    // ------------------------------------------------------------------
    sqrt_stage_t      sq_end;
    logic [31:0]      root_end;
    logic             vm_reg;
    logic             zm_reg;
    logic [2:0]       negm_reg;
    logic [63:0]      plo_reg;
    logic [63:0]      phi_reg;
    logic [31:0]      rootm_reg;
    logic [2:0][62:0] nm_reg;

    assign sq_end   = sqrt_reg[SQRT_STEPS];
    assign root_end = sq_end.root[31:0];

    always_ff @(posedge clk)
    begin
        plo_reg   <= sq_end.s[31:0] * root_end;
        phi_reg   <= sq_end.s[63:32] * root_end;
        for (int k = 0; k < 3; k++)
            nm_reg[k] <= 63'(mass_reg) * 63'(sq_end.mag[k]);
        rootm_reg <= root_end;
        zm_reg    <= sq_end.zero;
        negm_reg  <= sq_end.neg;
    end

    // ------------------------------------------------------------------
    // Add stage: denominator s*r and scaled numerators
    // ------------------------------------------------------------------
    logic              va_reg;
    logic              za_reg;
    logic [2:0]        nega_reg;
    logic [FDEN_W-1:0] den_reg;
    logic [2:0][FNUM_W-1:0] fnum_reg;
    logic [PNUM_W-1:0] pnum_reg;
    logic [PDEN_W-1:0] pden_reg;

    always_ff @(posedge clk)
    begin
        den_reg  <= FDEN_W'(plo_reg) + (FDEN_W'(phi_reg) << 32);
        for (int k = 0; k < 3; k++)
            fnum_reg[k] <= FNUM_W'(nm_reg[k]) << (2 * FRAC_BITS);
        pnum_reg <= PNUM_W'(mass_reg) << FRAC_BITS;
        pden_reg <= rootm_reg;
        za_reg   <= zm_reg;
        nega_reg <= negm_reg;
    end

    // Valid bits of the short stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v_sqrt_reg[0] <= 1'b0;
            vm_reg        <= 1'b0;
            va_reg        <= 1'b0;
        end
        else
        begin
            v1_reg        <= start;
            v2_reg        <= v1_reg;
            v_sqrt_reg[0] <= v2_reg;
            vm_reg        <= v_sqrt_reg[SQRT_STEPS];
            va_reg        <= vm_reg;
        end
    end

    // ------------------------------------------------------------------
    // Dividers: three force quotients and the potential quotient
    // ------------------------------------------------------------------
    logic [QUO_W-1:0] fq_x, fq_y, fq_z, pq;
    logic             fo_x, fo_y, fo_z, po;
    logic [1:0]       tag_x;
    logic             neg_y, neg_z, zero_p;

    sgfp_div #(.NUM_W(FNUM_W), .DEN_W(FDEN_W), .QUO_W(QUO_W), .TAG_W(2)) u_div_x (
        .clk(clk), .rst_n(rst_n), .num(fnum_reg[0]), .den(den_reg),
        .tag_in({va_reg, nega_reg[0]}), .quo(fq_x), .ovf(fo_x), .tag_out(tag_x)
    );

    sgfp_div #(.NUM_W(FNUM_W), .DEN_W(FDEN_W), .QUO_W(QUO_W), .TAG_W(1)) u_div_y (
        .clk(clk), .rst_n(rst_n), .num(fnum_reg[1]), .den(den_reg),
        .tag_in(nega_reg[1]), .quo(fq_y), .ovf(fo_y), .tag_out(neg_y)
    );

    sgfp_div #(.NUM_W(FNUM_W), .DEN_W(FDEN_W), .QUO_W(QUO_W), .TAG_W(1)) u_div_z (
        .clk(clk), .rst_n(rst_n), .num(fnum_reg[2]), .den(den_reg),
        .tag_in(nega_reg[2]), .quo(fq_z), .ovf(fo_z), .tag_out(neg_z)
    );

    sgfp_div #(.NUM_W(PNUM_W), .DEN_W(PDEN_W), .QUO_W(QUO_W), .TAG_W(1)) u_div_p (
        .clk(clk), .rst_n(rst_n), .num(pnum_reg), .den(pden_reg),
        .tag_in(za_reg), .quo(pq), .ovf(po), .tag_out(zero_p)
    );

    // ------------------------------------------------------------------
    // Saturation and output register
    // ------------------------------------------------------------------
    function automatic logic [31:0] sat_force(input logic [31:0] q, input logic ov,
                                              input logic neg_pos);
        logic [31:0] m;
        if (neg_pos)
        begin
            // Position negative: force pushes positive.
            m = (ov || q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q;
            return m;
        end
        else
        begin
            m = (ov || q > 32'h8000_0000) ? 32'h8000_0000 : q;
            return 32'd0 - m;
        end
    endfunction

    logic        done_reg;
    logic [31:0] fx_reg, fy_reg, fz_reg, pot_reg;

    always_ff @(posedge clk)
    begin
        if (zero_p)
        begin
            fx_reg  <= '0;
            fy_reg  <= '0;
            fz_reg  <= '0;
            pot_reg <= 32'h8000_0000;
        end
        else
        begin
            fx_reg  <= sat_force(fq_x, fo_x, tag_x[0]);
            fy_reg  <= sat_force(fq_y, fo_y, neg_y);
            fz_reg  <= sat_force(fq_z, fo_z, neg_z);
            pot_reg <= (po || pq[31]) ? 32'h8000_0000 : (32'd0 - pq);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= tag_x[1];
    end

    assign done      = done_reg;
    assign force_x   = fx_reg;
    assign force_y   = fy_reg;
    assign force_z   = fz_reg;
    assign potential = pot_reg;

endmodule
